// ===== design/tcw_pkg.sv =====
// Shared constants, payload structs and control types for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 24;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int SCROLL_SPAN = COLUMNS * (ROWS - 1);

   localparam int ADDR_W   = $clog2(CELL_COUNT);
   localparam int CNT_W    = $clog2(CELL_COUNT + 1);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int CURSOR_W = 11;
   localparam int INDEX_W  = 11;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = ATTR_W + CHAR_W;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

   localparam logic ACTION_PUT  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [CHAR_W-1:0]    char_code;
      logic [INDEX_W-1:0]   cell_index;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_value;
      logic [CURSOR_W-1:0]  cursor;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [CELL_W-1:0]    data;
   } ram_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
   } ram_rd_type;

   typedef struct packed {
      logic                 strobe;
      logic                 from_ram;
      logic [CURSOR_W-1:0]  cursor;
   } rsp_ctl_type;

   typedef enum logic [1:0] {
      ST_WIPE,
      ST_IDLE,
      ST_COPY,
      ST_FILL
   } state_type;

endpackage

// ===== design/text_console_writer.sv =====
// Top level of the text console writer: sequencer, cell memory and result port.
//
// Usage: drive req_payload and raise start; the item transfers at a clock edge
// where start is high and busy is low. Every item gives one result on
// rsp_payload, marked by rsp_strobe for exactly one cycle; the receiver
// cannot stall it. Results arrive in order; all but a scrolling put give
// theirs in the cycle after the transfer. While busy is low, ordinary
// characters, newlines and reads go at one item per cycle; a read returns
// the registered output of the cell memory. A character put with the cursor
// past the end scrolls: a copy pass over the memory moves the rows up, then
// a fill pass clears the last row and writes the character, with busy high
// throughout; its result follows the fill pass. Both passes go through the
// single memory write port.
// After reset busy stays high while a clearing pass zeroes the cell memory;
// the cursor resets past the end and the attribute to 7. csr_wr_en with
// csr_wr_data writes the attribute at any edge; write it only while no item
// is in flight.
`timescale 1ns / 1ps
module text_console_writer
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data
);

   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   rsp_ctl_type       rsp_ctl;
   logic [CELL_W-1:0] rd_data;

   tcw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rd_data     (rd_data),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .rsp_ctl     (rsp_ctl)
   );

   tcw_cell_ram u_cell_ram (
      .clock   (clock),
      .ram_wr  (ram_wr),
      .ram_rd  (ram_rd),
      .rd_data (rd_data)
   );

   assign rsp_strobe             = rsp_ctl.strobe;
   assign rsp_payload.cell_value = rsp_ctl.from_ram ? rd_data : '0;
   assign rsp_payload.cursor     = rsp_ctl.cursor;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.cursor <= CURSOR_W'(CELL_COUNT)))
      else $error("cursor beyond end of screen");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.action == ACTION_READ) |=> rsp_strobe)
      else $error("read transfer without result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while sequencer busy");

   a_scroll_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.action == ACTION_PUT
       && req_payload.char_code != NEWLINE_CODE
       && rsp_ctl.cursor == CURSOR_W'(CELL_COUNT)) |=> (busy && !rsp_strobe))
      else $error("scroll did not hold off input");

endmodule

// ===== design/tcw_cell_ram.sv =====
// Screen cell memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module tcw_cell_ram
   import tcw_pkg::*;
(
   input  logic              clock,
   input  ram_wr_type        ram_wr,
   input  ram_rd_type        ram_rd,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem_ff [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_wr.en) begin
         mem_ff[ram_wr.addr] <= ram_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd.en) begin
         rd_data_ff <= mem_ff[ram_rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tcw_ctrl.sv =====
// Sequencer: cursor tracking, clearing pass, scroll copy and row fill, memory access control.
`timescale 1ns / 1ps
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data,
   input  logic [CELL_W-1:0] rd_data,
   output ram_wr_type        ram_wr,
   output ram_rd_type        ram_rd,
   output rsp_ctl_type       rsp_ctl
);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CURSOR_W-1:0]   cursor_ff, cursor_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ATTR_W-1:0]     attr_ff, attr_in;
   logic [CHAR_W-1:0]     code_ff, code_in;
   logic                  strobe_ff, strobe_in;
   logic                  from_ram_ff, from_ram_in;

   logic                  accept;
   logic                  is_put;
   logic                  is_nl;
   logic                  at_end;
   logic                  scroll_go;
   logic                  plain_put;
   logic                  last_copy;
   logic                  last_cell;
   logic [CNT_W-1:0]      copy_src;
   logic [CNT_W-1:0]      copy_dst;

   assign accept    = start && !busy;
   assign is_put    = (req_payload.action == ACTION_PUT);
   assign is_nl     = (req_payload.char_code == NEWLINE_CODE);
   assign at_end    = (cursor_ff >= CURSOR_W'(CELL_COUNT));
   assign scroll_go = accept && is_put && !is_nl && at_end;
   assign plain_put = accept && is_put && !is_nl && !at_end;
   assign last_copy = (cnt_ff == CNT_W'(SCROLL_SPAN));
   assign last_cell = (cnt_ff == CNT_W'(CELL_COUNT - 1));
   assign copy_src  = cnt_ff + CNT_W'(COLUMNS);
   assign copy_dst  = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE: begin
            if (last_cell) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (scroll_go) state_in = ST_COPY;
         end
         ST_COPY: begin
            if (last_copy) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (last_cell) state_in = ST_IDLE;
         end
         default: state_in = ST_WIPE;
      endcase
   end

   always_comb begin
      busy   = 1'b1;
      ram_wr = '0;
      ram_rd = '0;
      unique case (state_ff)
         ST_WIPE: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff[ADDR_W-1:0];
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (plain_put) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = cursor_ff[ADDR_W-1:0];
               ram_wr.data = {attr_ff, req_payload.char_code};
            end
            if (accept && !is_put) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = req_payload.cell_index[ADDR_W-1:0];
            end
         end
         ST_COPY: begin
            if (!last_copy) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = copy_src[ADDR_W-1:0];
            end
            if (cnt_ff != '0) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = copy_dst[ADDR_W-1:0];
               ram_wr.data = rd_data;
            end
         end
         ST_FILL: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff[ADDR_W-1:0];
            if (last_copy) ram_wr.data = {attr_ff, code_ff};
         end
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      cnt_in      = cnt_ff;
      cursor_in   = cursor_ff;
      col_in      = col_ff;
      code_in     = code_ff;
      attr_in     = csr_wr_en ? csr_wr_data : attr_ff;
      strobe_in   = (accept && !scroll_go) || (state_ff == ST_FILL && last_cell);
      from_ram_in = accept && !is_put
                    && (req_payload.cell_index < INDEX_W'(CELL_COUNT));
      case (state_ff)
         ST_WIPE: cnt_in = cnt_ff + CNT_W'(1);
         ST_COPY: if (!last_copy) cnt_in = cnt_ff + CNT_W'(1);
         ST_FILL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_cell) begin
               cursor_in = CURSOR_W'(SCROLL_SPAN + 1);
               col_in    = COL_W'(1);
            end
         end
         default: begin
            if (scroll_go) begin
               cnt_in  = '0;
               code_in = req_payload.char_code;
            end
            if (plain_put) begin
               cursor_in = cursor_ff + CURSOR_W'(1);
               col_in    = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
            end
            if (accept && is_put && is_nl && !at_end) begin
               cursor_in = cursor_ff + (CURSOR_W'(COLUMNS) - CURSOR_W'(col_ff));
               col_in    = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WIPE;
         cnt_ff      <= '0;
         cursor_ff   <= CURSOR_W'(CELL_COUNT);
         col_ff      <= '0;
         attr_ff     <= ATTR_RESET;
         strobe_ff   <= 1'b0;
         from_ram_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cursor_ff   <= cursor_in;
         col_ff      <= col_in;
         attr_ff     <= attr_in;
         strobe_ff   <= strobe_in;
         from_ram_ff <= from_ram_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign rsp_ctl.strobe   = strobe_ff;
   assign rsp_ctl.from_ram = from_ram_ff;
   assign rsp_ctl.cursor   = cursor_ff;

endmodule
